[rtl/textured_column_span_stepper_top_assert.svh]
// Assertion macros shared by the column span stepper RTL.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef TEXTURED_COLUMN_SPAN_STEPPER_TOP_ASSERT_SVH
`define TEXTURED_COLUMN_SPAN_STEPPER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Consequence holds in the same cycle as the condition.
`define TCSS_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("span stepper assertion failed");
// Consequence holds in the cycle after the condition.
`define TCSS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("span stepper assertion failed");
`else
`define TCSS_ASSERT_NOW(label, clk, rst_n, cond, cons)
`define TCSS_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

[rtl/tcss_pkg.sv]
package tcss_pkg;

	localparam int TEX_MAX_SIZE = 64;
	localparam int TEX_ROW_W    = $clog2(TEX_MAX_SIZE);
	localparam int TEX_INT_W    = 7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEX_HEIGHT_LOG2 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TEX_ROW_PITCH  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEX_BPP        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TEX_BASE       = 3'd4;

	localparam logic [11:0] RST_SCREEN_HEIGHT   = 12'd480;
	localparam logic [2:0]  RST_TEX_HEIGHT_LOG2 = 3'd6;
	localparam logic [15:0] RST_TEX_ROW_PITCH   = 16'd256;
	localparam logic [3:0]  RST_TEX_BPP         = 4'd4;
	localparam logic [31:0] RST_TEX_BASE        = 32'd0;

	typedef struct packed {
		logic        command;
		logic [11:0] column_x;
		logic [11:0] span_start;
		logic [11:0] span_end;
		logic [15:0] wall_height;
		logic [5:0]  tex_column;
	} tcss_cmd_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [5:0]  tex_row;
		logic [31:0] texel_address;
		logic        last;
	} tcss_pix_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tcss_div_stat_t;

endpackage

[rtl/tcss_divider.sv]
module tcss_divider import tcss_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0]             log2,
	input  logic [15:0]            divisor,
	output logic [FRAC_BITS+6:0]   quotient,
	output tcss_div_stat_t         stat
);

	// The dividend is 1 << (log2 + FRAC_BITS), which needs one bit more than the step.
	localparam int QW = FRAC_BITS + 8;
	localparam int SW = FRAC_BITS + 7;
	localparam int CW = $clog2(QW);

	logic [QW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [15:0]   rem_q;
	logic [15:0]   div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	assign trial = {rem_q, num_q[QW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
				num_q  <= QW'(1) << (int'(log2) + FRAC_BITS);
				quo_q  <= '0;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[15:0] : trial[15:0];
				quo_q <= {quo_q[QW-2:0], ge};
				num_q <= {num_q[QW-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A quotient that does not fit the step width saturates; a zero divisor lands here too.
	assign quotient = quo_q[QW-1] ? {SW{1'b1}} : quo_q[SW-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/textured_column_span_stepper_top.sv]
// Textured column span stepper for a raycasting renderer.
// The cmd channel (cmd_valid / cmd_stall / cmd) takes two kinds of transaction.
// A load transaction latches one wall column and runs a restoring divider, one
// quotient bit per cycle, then a multiply step for the start position; cmd_stall
// stays high while the divider and the multiply run, and a load produces no pixel.
// A step transaction produces one pixel on the pix channel (pix_valid / pix_stall /
// pix) in the cycle after it is taken, so steps flow at one per cycle unless the
// receiver stalls; a step with no active span is consumed silently.
// The pixel sits in an output register; when the receiver stalls it, the register
// holds and cmd_stall rises until it is taken, so nothing is dropped or repeated.
// The cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready and
// must only be used while the block is idle; unknown indexes are ignored.
// Reset (arst_n low) restores the register defaults and clears any span.
`include "textured_column_span_stepper_top_assert.svh"

module textured_column_span_stepper_top import tcss_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  tcss_cmd_t              cmd,
	output logic                   pix_valid,
	input  logic                   pix_stall,
	output tcss_pix_t              pix,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam int SW  = FRAC_BITS + 7;
	localparam int OFW = 18;
	localparam int PW  = OFW + SW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [11:0] screen_height_q;
	logic [2:0]  tex_height_log2_q;
	logic [15:0] tex_row_pitch_q;
	logic [3:0]  tex_bpp_q;
	logic [31:0] tex_base_q;

	// Span state.
	logic [11:0]    cur_x_q;
	logic [11:0]    cur_row_q;
	logic [11:0]    end_row_q;
	logic [31:0]    tex_pos_q;
	logic [SW-1:0]  tex_step_q;
	logic [5:0]     cur_tex_col_q;
	logic           span_active_q;
	logic signed [OFW-1:0] offset_q;

	// Output register.
	logic      pix_valid_q;
	tcss_pix_t pix_q;

	logic           cmd_take;
	logic           load_take;
	logic           step_take;
	logic           div_start;
	logic [SW-1:0]  div_quotient;
	tcss_div_stat_t div_stat;

	logic [TEX_INT_W-1:0] int_lo;
	logic [TEX_INT_W-1:0] height_mask;
	logic [TEX_ROW_W-1:0] row;
	logic [21:0]          row_offset;
	logic [9:0]           col_offset;
	logic [31:0]          texel_address;
	logic                 is_last;
	logic signed [OFW-1:0] offset_new;
	logic signed [PW-1:0]  start_prod;

	// The block waits while the divider and the start multiply run and while a stalled pixel is pending.
	assign cmd_stall = (state_q != ST_IDLE) || (pix_valid_q && pix_stall);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign load_take = cmd_take && (cmd.command == CMD_LOAD);
	assign step_take = cmd_take && (cmd.command == CMD_STEP) && span_active_q;
	assign div_start = load_take;
	assign cfg_ready = 1'b1;

	tcss_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.log2    (tex_height_log2_q),
		.divisor (cmd.wall_height),
		.quotient(div_quotient),
		.stat    (div_stat)
	);

	// Start offset: span_start - screen_height/2 + wall_height/2, both halvings truncate.
	assign offset_new = $signed({6'b0, cmd.span_start})
		- $signed({7'b0, screen_height_q[11:1]})
		+ $signed({3'b0, cmd.wall_height[15:1]});

	assign start_prod = offset_q * $signed({1'b0, tex_step_q});

	// Integer part truncated toward zero: a negative position with a nonzero fraction
	// rounds up by one from the arithmetic shift. Only the low bits are needed.
	assign int_lo = tex_pos_q[FRAC_BITS +: TEX_INT_W]
		+ TEX_INT_W'(tex_pos_q[31] && (tex_pos_q[FRAC_BITS-1:0] != '0));
	assign height_mask = TEX_INT_W'((8'd1 << tex_height_log2_q) - 8'd1);
	assign row         = TEX_ROW_W'(int_lo & height_mask);
	assign row_offset  = 22'(row) * 22'(tex_row_pitch_q);
	assign col_offset  = 10'(cur_tex_col_q) * 10'(tex_bpp_q);
	assign texel_address = tex_base_q + 32'(row_offset) + 32'(col_offset);
	assign is_last       = (cur_row_q >= end_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			screen_height_q   <= RST_SCREEN_HEIGHT;
			tex_height_log2_q <= RST_TEX_HEIGHT_LOG2;
			tex_row_pitch_q   <= RST_TEX_ROW_PITCH;
			tex_bpp_q         <= RST_TEX_BPP;
			tex_base_q        <= RST_TEX_BASE;
			cur_x_q           <= '0;
			cur_row_q         <= '0;
			end_row_q         <= '0;
			tex_pos_q         <= '0;
			tex_step_q        <= '0;
			cur_tex_col_q     <= '0;
			span_active_q     <= 1'b0;
			offset_q          <= '0;
			pix_valid_q       <= 1'b0;
			pix_q             <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SCREEN_HEIGHT:   screen_height_q   <= cfg_data[11:0];
					REG_TEX_HEIGHT_LOG2: tex_height_log2_q <= cfg_data[2:0];
					REG_TEX_ROW_PITCH:   tex_row_pitch_q   <= cfg_data[15:0];
					REG_TEX_BPP:         tex_bpp_q         <= cfg_data[3:0];
					REG_TEX_BASE:        tex_base_q        <= cfg_data;
					default: ;
				endcase
			end

			// A taken pixel leaves the register unless a new step refills it.
			if (pix_valid_q && !pix_stall && !step_take) begin
				pix_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (load_take) begin
						// Geometry of the new span is known at once; the step and
						// start position follow from the divider.
						cur_x_q       <= cmd.column_x;
						cur_tex_col_q <= cmd.tex_column;
						end_row_q     <= cmd.span_end;
						offset_q      <= offset_new;
						if (cmd.span_end > cmd.span_start) begin
							cur_row_q     <= cmd.span_start + 12'd1;
							span_active_q <= 1'b1;
						end else begin
							cur_row_q     <= cmd.span_start;
							span_active_q <= 1'b0;
						end
						state_q <= ST_DIV;
					end else if (step_take) begin
						pix_valid_q         <= 1'b1;
						pix_q.pixel_x       <= cur_x_q;
						pix_q.pixel_y       <= cur_row_q;
						pix_q.tex_row       <= row;
						pix_q.texel_address <= texel_address;
						pix_q.last          <= is_last;
						tex_pos_q           <= tex_pos_q + 32'(tex_step_q);
						cur_row_q           <= cur_row_q + 12'd1;
						if (is_last) begin
							span_active_q <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						tex_step_q <= div_quotient;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					// The start position wraps to 32 bits.
					tex_pos_q <= start_prod[31:0];
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	`TCSS_ASSERT_NEXT(a_load_starts_div, clk, arst_n, load_take, (state_q == ST_DIV) && div_stat.busy)
	`TCSS_ASSERT_NOW(a_done_only_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV)
	`TCSS_ASSERT_NOW(a_span_rows_ordered, clk, arst_n, span_active_q, cur_row_q <= end_row_q)
	`TCSS_ASSERT_NEXT(a_last_closes_span, clk, arst_n, step_take && is_last, pix_valid && pix.last && !span_active_q)

endmodule

[tb/textured_column_span_stepper_top_test.sv]
module textured_column_span_stepper_top_test;
	import tcss_pkg::*;

	// Fraction bits of the texture position; the block is built with the same value.
	localparam int FRAC = 16;
	// Width of the unsigned texture step: integer bits plus fraction bits.
	localparam int STEP_W = TEX_INT_W + FRAC;
	localparam logic [63:0] STEP_ONES = (64'd1 << STEP_W) - 64'd1;
	// A load stalls the block while the divider and the start multiply run and produces no
	// pixel, so the block is only known to be idle once the settle time below has passed.
	localparam int SETTLE_CYCLES = FRAC + 24;

	// Predicts the pixel stream of the stepper. It keeps its own copy of the texture
	// registers and of the span state, and queues one expected pixel per step
	// transaction that falls inside an active span.
	class span_pixel_predictor;
		logic [11:0]       screen_h;
		logic [2:0]        tex_log2;
		logic [15:0]       row_pitch;
		logic [3:0]        texel_bytes;
		logic [31:0]       tex_base;
		logic [11:0]       col_x;
		logic [11:0]       row_now;
		logic [11:0]       row_end;
		logic [31:0]       tex_pos;
		logic [STEP_W-1:0] tex_step;
		logic [5:0]        tex_col;
		bit                span_live;
		tcss_pix_t         due_pixels[$];
		int                errors;
		int                loads;
		int                pixels;
		int                idle_steps;

		function new();
			screen_h = RST_SCREEN_HEIGHT;
			tex_log2 = RST_TEX_HEIGHT_LOG2;
			row_pitch = RST_TEX_ROW_PITCH;
			texel_bytes = RST_TEX_BPP;
			tex_base = RST_TEX_BASE;
			col_x = '0;
			row_now = '0;
			row_end = '0;
			tex_pos = '0;
			tex_step = '0;
			tex_col = '0;
			span_live = 0;
			errors = 0;
			loads = 0;
			pixels = 0;
			idle_steps = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_SCREEN_HEIGHT: screen_h = data[11:0];
				REG_TEX_HEIGHT_LOG2: tex_log2 = data[2:0];
				REG_TEX_ROW_PITCH: row_pitch = data[15:0];
				REG_TEX_BPP: texel_bytes = data[3:0];
				REG_TEX_BASE: tex_base = data;
				default: ;
			endcase
		endfunction

		function void note_command(tcss_cmd_t c);
			logic [63:0] quot;
			longint      start_l;
			longint      half_screen;
			longint      half_wall;
			longint      step_l;
			longint      offset;
			logic [63:0] product;
			logic [31:0] whole;
			logic [31:0] mag;
			logic [31:0] row;
			logic [31:0] addr;
			tcss_pix_t   px;
			if (c.command == CMD_LOAD) begin
				loads++;
				if (c.wall_height == 16'd0) begin
					quot = STEP_ONES;
				end else begin
					quot = (64'd1 << (tex_log2 + FRAC)) / c.wall_height;
					if (quot > STEP_ONES)
						quot = STEP_ONES;
				end
				start_l = c.span_start;
				half_screen = screen_h >> 1;
				half_wall = c.wall_height >> 1;
				step_l = quot;
				offset = start_l - half_screen + half_wall;
				product = offset * step_l;
				tex_pos = product[31:0];
				tex_step = quot[STEP_W-1:0];
				col_x = c.column_x;
				tex_col = c.tex_column;
				row_end = c.span_end;
				span_live = c.span_end > c.span_start;
				row_now = span_live ? c.span_start + 12'd1 : c.span_start;
			end else if (!span_live) begin
				idle_steps++;
			end else begin
				// The integer part truncates toward zero, also for negative positions.
				if (tex_pos[31]) begin
					mag = (-tex_pos) >> FRAC;
					whole = -mag;
				end else begin
					whole = tex_pos >> FRAC;
				end
				row = (whole & ((32'd1 << tex_log2) - 32'd1)) % TEX_MAX_SIZE;
				addr = tex_base + row * row_pitch + tex_col * texel_bytes;
				px.pixel_x = col_x;
				px.pixel_y = row_now;
				px.tex_row = row[5:0];
				px.texel_address = addr;
				px.last = row_now >= row_end;
				due_pixels.push_back(px);
				tex_pos = tex_pos + {{(32-STEP_W){1'b0}}, tex_step};
				row_now = row_now + 12'd1;
				if (px.last)
					span_live = 0;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(tcss_pix_t got);
			tcss_pix_t want;
			if (due_pixels.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = due_pixels.pop_front();
				pixels++;
				compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
				compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
				compare_field("tex_row", 32'(want.tex_row), 32'(got.tex_row));
				compare_field("texel_address", want.texel_address, got.texel_address);
				compare_field("last", 32'(want.last), 32'(got.last));
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	tcss_cmd_t              cmd = '0;
	logic                   pix_valid;
	logic                   pix_stall = 1'b0;
	tcss_pix_t              pix;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	span_pixel_predictor pixel_model = new();

	// Chance in percent that the sender or the receiver idles in a given cycle.
	int send_idle_pct = 31;
	int recv_idle_pct = 31;
	// Set by the stimulus to ask the receiver for one long hold-off of this many cycles.
	int hold_request = 0;
	int hold_left = 0;
	int settings_used = 1;

	textured_column_span_stepper_top #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver. The handshake signals are read at the edge before this process drives
	// the next stall value, so the check sees what the block saw. A long hold-off is
	// counted down here, independent of the stimulus.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			pixel_model.check_pixel(pix);
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic tcss_cmd_t load_cmd(logic [11:0] x, logic [11:0] first,
			logic [11:0] stop, logic [15:0] wall, logic [5:0] col);
		tcss_cmd_t c;
		c.command = CMD_LOAD;
		c.column_x = x;
		c.span_start = first;
		c.span_end = stop;
		c.wall_height = wall;
		c.tex_column = col;
		return c;
	endfunction

	// Fully random payload; the span fields of a step transaction must be ignored.
	function automatic tcss_cmd_t random_cmd();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(tcss_cmd_t)-1:0];
	endfunction

	// Some short walls (steep steps), more tall ones, and now and then zero height.
	function automatic logic [15:0] pick_wall_height();
		case ($urandom_range(19))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(1, 16));
			6, 7, 8, 9, 10, 11: return 16'($urandom_range(1, 1024));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	// Offers one transaction, with random idle cycles ahead of it, and holds it until
	// the block takes it.
	task automatic offer_command(tcss_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pixel_model.note_command(c);
	endtask

	task automatic offer_steps(int n);
		tcss_cmd_t c;
		repeat (n) begin
			c = random_cmd();
			c.command = CMD_STEP;
			offer_command(c);
		end
	endtask

	// The sender pauses until every expected pixel has arrived, then gives a load that
	// may still sit in the divider time to finish.
	task automatic wait_until_idle();
		cmd_valid <= 1'b0;
		while (pixel_model.due_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pixel_model.write_reg(idx, data);
	endtask

	// Writes all configuration registers plus one index that the block must ignore.
	task automatic program_texture(logic [11:0] sh, logic [2:0] lg, logic [15:0] pitch,
			logic [3:0] bpp, logic [31:0] base);
		wait_until_idle();
		write_reg(REG_SCREEN_HEIGHT, 32'(sh));
		write_reg(REG_TEX_HEIGHT_LOG2, 32'(lg));
		write_reg(REG_TEX_ROW_PITCH, 32'(pitch));
		write_reg(REG_TEX_BPP, 32'(bpp));
		write_reg(REG_TEX_BASE, base);
		write_reg(CFG_INDEX_W'(REG_TEX_BASE + $urandom_range(1, 3)), $urandom());
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Random traffic. Most of it is a load followed by exactly the steps of its span;
	// some spans are cut short by the next load, some get extra steps past their end,
	// and the rest is raw random transactions.
	task automatic run_spans(int budget);
		int          made;
		int          len;
		int          steps;
		int          kind;
		logic [11:0] first;
		made = 0;
		while (made < budget) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
				first = 12'($urandom_range(0, 4095 - len));
				offer_command(load_cmd(12'($urandom_range(4095)), first, first + 12'(len),
					pick_wall_height(), 6'($urandom_range(63))));
				steps = len;
				if (kind < 8)
					steps = $urandom_range(0, len - 1);
				else if (kind < 16)
					steps = len + $urandom_range(1, 3);
				offer_steps(steps);
				made += 1 + steps;
			end else begin
				offer_command(random_cmd());
				made++;
			end
		end
	endtask

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values.
		// A step before any load must produce nothing.
		offer_steps(1);
		// Zero wall height gives the all-ones step; widest column and texture column.
		offer_command(load_cmd(12'd4095, 12'd10, 12'd14, 16'd0, 6'd63));
		offer_steps(4);
		// Empty spans: end equal to start, then end below start.
		offer_command(load_cmd(12'd5, 12'd20, 12'd20, 16'hFFFF, 6'd1));
		offer_steps(1);
		offer_command(load_cmd(12'd6, 12'd30, 12'd5, 16'd300, 6'd2));
		offer_steps(1);
		// A load replaces a span in progress. The second span starts with a position
		// that wraps past 32 bits and runs to the last screen row.
		offer_command(load_cmd(12'd0, 12'd0, 12'd50, 16'd1, 6'd0));
		offer_steps(2);
		offer_command(load_cmd(12'd2048, 12'd4090, 12'd4095, 16'd1, 6'd32));
		offer_steps(5);
		// Negative start position.
		offer_command(load_cmd(12'd100, 12'd0, 12'd3, 16'd100, 6'd21));
		offer_steps(3);

		// All-ones registers: one-row texture, widest pitch and texel, base that wraps.
		program_texture(12'hFFF, 3'd0, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
		run_spans(120);

		// All-zero registers; a height code of seven saturates the step on walls of height one.
		program_texture(12'd0, 3'd7, 16'd0, 4'd0, 32'd0);
		run_spans(120);

		// Back pressure: the receiver holds off for a long time while the sender keeps
		// offering steps, so the output register fills and the block stalls its input.
		program_texture(12'd1, 3'd3, 16'($urandom()), 4'($urandom_range(1, 8)), $urandom());
		offer_command(load_cmd(12'd7, 12'd100, 12'd420, pick_wall_height(), 6'd9));
		hold_request = 200;
		offer_steps(260);

		// The span above is still active; new pitch, base, bytes per texel and mask
		// apply to its remaining pixels. This stretch runs with no idling at all.
		program_texture(RST_SCREEN_HEIGHT, RST_TEX_HEIGHT_LOG2, RST_TEX_ROW_PITCH,
			RST_TEX_BPP, RST_TEX_BASE);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		offer_steps(6);
		run_spans(150);
		send_idle_pct = 31;
		recv_idle_pct = 31;

		repeat (3) begin
			program_texture(12'($urandom()), 3'($urandom_range(0, 6)), 16'($urandom()),
				4'($urandom_range(1, 8)), $urandom());
			run_spans(60);
		end

		wait_until_idle();
		$display("Run covered %0d loads and %0d checked pixels over %0d register settings;",
			pixel_model.loads, pixel_model.pixels, settings_used);
		$display("%0d step transactions arrived with no span active.", pixel_model.idle_steps);
		if (pixel_model.errors == 0 && pixel_model.due_pixels.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
